// File: src/lse_pkg.sv
package lse_pkg;

   localparam int NUM_REGS = 8;
   localparam int RSPQ_DEPTH = 2;
   localparam logic [15:0] HIGH_PAGE = 16'hFF00;

   localparam logic [2:0] REG_C = 3'd1;
   localparam logic [2:0] REG_H = 3'd4;
   localparam logic [2:0] REG_L = 3'd5;
   localparam logic [2:0] REG_A = 3'd7;

   localparam logic [1:0] PAIR_SP = 2'd3;

   typedef enum logic [4:0] {
      OP_LD_R_R     = 5'd0,
      OP_LD_R_N8    = 5'd1,
      OP_LD_RR_N16  = 5'd2,
      OP_ST_HL_R    = 5'd3,
      OP_ST_HL_N8   = 5'd4,
      OP_LD_R_HL    = 5'd5,
      OP_ST_RR_A    = 5'd6,
      OP_ST_N16_A   = 5'd7,
      OP_STH_N8_A   = 5'd8,
      OP_STH_C_A    = 5'd9,
      OP_LD_A_RR    = 5'd10,
      OP_LD_A_N16   = 5'd11,
      OP_LDH_A_N8   = 5'd12,
      OP_LDH_A_C    = 5'd13,
      OP_ST_HLI_A   = 5'd14,
      OP_ST_HLD_A   = 5'd15,
      OP_LD_A_HLD   = 5'd16,
      OP_LD_A_HLI   = 5'd17
   } op_type;

   typedef enum logic [1:0] {
      ACC_NONE  = 2'd0,
      ACC_READ  = 2'd1,
      ACC_WRITE = 2'd2
   } access_type;

   typedef struct packed {
      access_type  access_kind;
      logic [15:0] access_addr;
      logic [7:0]  access_byte;
      logic [7:0]  acc_value;
      logic [15:0] hl_value;
   } rsp_payload_type;

endpackage

// File: src/lse_ifs.sv
interface lse_req_if;
   logic        valid;
   logic        ready;
   logic [4:0]  op;
   logic [2:0]  target_reg;
   logic [2:0]  source_reg;
   logic [1:0]  pair_sel;
   logic [15:0] imm;

   modport source (output valid, op, target_reg, source_reg, pair_sel, imm, input ready);
   modport sink (input valid, op, target_reg, source_reg, pair_sel, imm, output ready);
endinterface

interface lse_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  access_kind;
   logic [15:0] access_addr;
   logic [7:0]  access_byte;
   logic [7:0]  acc_value;
   logic [15:0] hl_value;

   modport source (output valid, access_kind, access_addr, access_byte, acc_value, hl_value,
                   input ready);
   modport sink (input valid, access_kind, access_addr, access_byte, acc_value, hl_value,
                 output ready);
endinterface

// File: src/lse_mem.sv
module lse_mem #(
   parameter int MEM_BYTES = 65536
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic                         rd_en,
   input  logic [$clog2(MEM_BYTES)-1:0] addr,
   input  logic [7:0]                   wr_data,
   output logic [7:0]                   rd_data,
   output logic                         busy
);

   localparam int AW = $clog2(MEM_BYTES);

   logic [7:0]    mem [MEM_BYTES];
   logic [7:0]    rd_data_ff;
   logic          clearing_ff;
   logic [AW-1:0] clr_addr_ff;

   // sweep zeros through the whole array after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == '1) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_addr_ff] <= 8'h00;
      end else if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clearing_ff;

endmodule

// File: src/lse_rspq.sv
module lse_rspq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  lse_pkg::rsp_payload_type push_data,
   lse_rsp_if.source                rsp_chan,
   output logic [1:0]               count
);

   lse_pkg::rsp_payload_type entries [lse_pkg::RSPQ_DEPTH];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       pop;

   assign pop = rsp_chan.valid && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= 2'(count_ff + {1'b0, push} - {1'b0, pop});
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_chan.valid       = (count_ff != 2'd0);
   assign rsp_chan.access_kind = entries[rd_ptr_ff].access_kind;
   assign rsp_chan.access_addr = entries[rd_ptr_ff].access_addr;
   assign rsp_chan.access_byte = entries[rd_ptr_ff].access_byte;
   assign rsp_chan.acc_value   = entries[rd_ptr_ff].acc_value;
   assign rsp_chan.hl_value    = entries[rd_ptr_ff].hl_value;
   assign count                = count_ff;

endmodule

// File: src/load_store_executor_8bit_cpu_unit.sv
// An accepted request is registered in s1, then pushed into the response queue. One
// request per cycle is taken while req_chan.ready is high (it drops when the queue is
// full); the memory read lands in the register file in the cycle after issue and is
// forwarded to the following request. Reset: registers and stack pointer clear at once;
// then all MEM_BYTES bytes (65536 by default) are zeroed with req_chan.ready held low.
module load_store_executor_8bit_cpu_unit #(
   parameter int MEM_BYTES = 65536
) (
   input logic       clock,
   input logic       reset,
   lse_req_if.sink   req_chan,
   lse_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(MEM_BYTES);

   logic [7:0]  regs_ff [lse_pkg::NUM_REGS];
   logic [7:0]  regs_in [lse_pkg::NUM_REGS];
   logic [7:0]  fwd [lse_pkg::NUM_REGS];
   logic [15:0] sp_ff;
   logic [15:0] sp_in;

   logic                 s1_valid_ff;
   lse_pkg::access_type  s1_kind_ff;
   logic [15:0]          s1_addr_ff;
   logic [7:0]           s1_wdata_ff;
   logic [2:0]           s1_dst_ff;
   logic                 s1_load;

   lse_pkg::op_type     op;
   lse_pkg::access_type d_kind;
   logic [15:0]         d_addr;
   logic [7:0]          d_wdata;
   logic [2:0]          d_dst;
   logic [15:0]         hl;
   logic [15:0]         pair_val;
   logic [7:0]          n8;
   logic                accept;

   logic       mem_busy;
   logic [7:0] mem_rdata;
   logic [1:0] q_count;
   logic [2:0] occupancy;
   logic       rsp_pop;
   lse_pkg::rsp_payload_type push_data;

   assign s1_load = s1_valid_ff && (s1_kind_ff == lse_pkg::ACC_READ);

   // forward the pending load into the register view
   always_comb begin
      for (int i = 0; i < lse_pkg::NUM_REGS; i++) begin
         fwd[i] = (s1_load && s1_dst_ff == 3'(i)) ? mem_rdata : regs_ff[i];
      end
   end

   assign op       = lse_pkg::op_type'(req_chan.op);
   assign n8       = req_chan.imm[7:0];
   assign hl       = {fwd[lse_pkg::REG_H], fwd[lse_pkg::REG_L]};
   assign pair_val = (req_chan.pair_sel == lse_pkg::PAIR_SP) ? sp_ff :
                     {fwd[{req_chan.pair_sel, 1'b0}], fwd[{req_chan.pair_sel, 1'b1}]};

   always_comb begin
      d_kind  = lse_pkg::ACC_NONE;
      d_addr  = 16'h0000;
      d_wdata = 8'h00;
      d_dst   = lse_pkg::REG_A;
      case (op)
         lse_pkg::OP_ST_HL_R: begin
            d_kind  = lse_pkg::ACC_WRITE;
            d_addr  = hl;
            d_wdata = fwd[req_chan.target_reg];
         end
         lse_pkg::OP_ST_HL_N8: begin
            d_kind  = lse_pkg::ACC_WRITE;
            d_addr  = hl;
            d_wdata = n8;
         end
         lse_pkg::OP_LD_R_HL: begin
            d_kind = lse_pkg::ACC_READ;
            d_addr = hl;
            d_dst  = req_chan.target_reg;
         end
         lse_pkg::OP_ST_RR_A: begin
            d_kind  = lse_pkg::ACC_WRITE;
            d_addr  = pair_val;
            d_wdata = fwd[lse_pkg::REG_A];
         end
         lse_pkg::OP_ST_N16_A: begin
            d_kind  = lse_pkg::ACC_WRITE;
            d_addr  = req_chan.imm;
            d_wdata = fwd[lse_pkg::REG_A];
         end
         lse_pkg::OP_STH_N8_A: begin
            d_kind  = lse_pkg::ACC_WRITE;
            d_addr  = lse_pkg::HIGH_PAGE | {8'h00, n8};
            d_wdata = fwd[lse_pkg::REG_A];
         end
         lse_pkg::OP_STH_C_A: begin
            d_kind  = lse_pkg::ACC_WRITE;
            d_addr  = lse_pkg::HIGH_PAGE | {8'h00, fwd[lse_pkg::REG_C]};
            d_wdata = fwd[lse_pkg::REG_A];
         end
         lse_pkg::OP_LD_A_RR: begin
            d_kind = lse_pkg::ACC_READ;
            d_addr = pair_val;
         end
         lse_pkg::OP_LD_A_N16: begin
            d_kind = lse_pkg::ACC_READ;
            d_addr = req_chan.imm;
         end
         lse_pkg::OP_LDH_A_N8: begin
            d_kind = lse_pkg::ACC_READ;
            d_addr = lse_pkg::HIGH_PAGE | {8'h00, n8};
         end
         lse_pkg::OP_LDH_A_C: begin
            d_kind = lse_pkg::ACC_READ;
            d_addr = lse_pkg::HIGH_PAGE | {8'h00, fwd[lse_pkg::REG_C]};
         end
         lse_pkg::OP_ST_HLI_A, lse_pkg::OP_ST_HLD_A: begin
            d_kind  = lse_pkg::ACC_WRITE;
            d_addr  = hl;
            d_wdata = fwd[lse_pkg::REG_A];
         end
         lse_pkg::OP_LD_A_HLD, lse_pkg::OP_LD_A_HLI: begin
            d_kind = lse_pkg::ACC_READ;
            d_addr = hl;
         end
         default: begin
            d_kind = lse_pkg::ACC_NONE;
         end
      endcase
   end

   assign rsp_pop   = rsp_chan.valid && rsp_chan.ready;
   assign occupancy = 3'({1'b0, q_count} + {2'b00, s1_valid_ff});
   assign req_chan.ready = !mem_busy && ((occupancy < 3'd2) || (occupancy == 3'd2 && rsp_pop));
   assign accept = req_chan.valid && req_chan.ready;

   // write back the pending load first so the newer request wins
   always_comb begin
      regs_in = regs_ff;
      sp_in   = sp_ff;
      if (s1_load) begin
         regs_in[s1_dst_ff] = mem_rdata;
      end
      if (accept) begin
         case (op)
            lse_pkg::OP_LD_R_R: begin
               regs_in[req_chan.target_reg] = fwd[req_chan.source_reg];
            end
            lse_pkg::OP_LD_R_N8: begin
               regs_in[req_chan.target_reg] = n8;
            end
            lse_pkg::OP_LD_RR_N16: begin
               if (req_chan.pair_sel == lse_pkg::PAIR_SP) begin
                  sp_in = req_chan.imm;
               end else begin
                  regs_in[{req_chan.pair_sel, 1'b0}] = req_chan.imm[15:8];
                  regs_in[{req_chan.pair_sel, 1'b1}] = req_chan.imm[7:0];
               end
            end
            lse_pkg::OP_ST_HLI_A, lse_pkg::OP_LD_A_HLI: begin
               {regs_in[lse_pkg::REG_H], regs_in[lse_pkg::REG_L]} = 16'(hl + 16'd1);
            end
            lse_pkg::OP_ST_HLD_A, lse_pkg::OP_LD_A_HLD: begin
               {regs_in[lse_pkg::REG_H], regs_in[lse_pkg::REG_L]} = 16'(hl - 16'd1);
            end
            default: begin
               sp_in = sp_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lse_pkg::NUM_REGS; i++) begin
            regs_ff[i] <= 8'h00;
         end
         sp_ff       <= 16'h0000;
         s1_valid_ff <= 1'b0;
      end else begin
         regs_ff     <= regs_in;
         sp_ff       <= sp_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff  <= d_kind;
         s1_addr_ff  <= d_addr;
         s1_wdata_ff <= d_wdata;
         s1_dst_ff   <= d_dst;
      end
   end

   lse_mem #(
      .MEM_BYTES(MEM_BYTES)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept && d_kind == lse_pkg::ACC_WRITE),
      .rd_en   (accept && d_kind == lse_pkg::ACC_READ),
      .addr    (d_addr[AW-1:0]),
      .wr_data (d_wdata),
      .rd_data (mem_rdata),
      .busy    (mem_busy)
   );

   assign push_data.access_kind = s1_kind_ff;
   assign push_data.access_addr = s1_addr_ff;
   assign push_data.access_byte = s1_load ? mem_rdata : s1_wdata_ff;
   assign push_data.acc_value   = fwd[lse_pkg::REG_A];
   assign push_data.hl_value    = {fwd[lse_pkg::REG_H], fwd[lse_pkg::REG_L]};

   lse_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_data (push_data),
      .rsp_chan  (rsp_chan),
      .count     (q_count)
   );

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (q_count != 2'd2 || rsp_pop))
      else $error("response queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted request lost before write-back");

   assert property (@(posedge clock) disable iff (reset)
      mem_busy |-> (!s1_valid_ff && q_count == 2'd0))
      else $error("request in flight during memory clear");
`endif

endmodule

// File: sim/load_store_executor_8bit_cpu_unit_tb.sv
module load_store_executor_8bit_cpu_unit_tb;
   import lse_pkg::*;

   localparam logic [2:0] REG_B = 3'd0;
   localparam logic [2:0] REG_F = 3'd6;
   localparam logic [1:0] PAIR_BC = 2'd0;
   localparam logic [1:0] PAIR_DE = 2'd1;
   localparam logic [1:0] PAIR_HL = 2'd2;
   localparam logic [4:0] OP_UNKNOWN_LO = 5'd18;
   localparam logic [4:0] OP_UNKNOWN_HI = 5'd31;
   localparam int RANDOM_INSTRS = 1700;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [4:0]  op;
      logic [2:0]  tgt;
      logic [2:0]  src;
      logic [1:0]  psel;
      logic [15:0] imm;
   } instr_t;

   logic clock;
   logic reset;

   lse_req_if req_chan ();
   lse_rsp_if rsp_chan ();

   load_store_executor_8bit_cpu_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   bit [7:0]  regs_m [0:NUM_REGS-1];
   bit [15:0] sp_m;
   bit [7:0]  mem_m [0:65535];

   instr_t         pending_instrs [$];
   rsp_payload_type expected_accesses [$];
   instr_t         drv_item;

   int n_sent;
   int n_checked;
   int n_reads;
   int n_writes;
   int n_errors;

   always #5 clock = ~clock;

   function automatic int stall_pct();
      if (n_sent >= 700 && n_sent < 1000) begin
         return 0;
      end
      return 30;
   endfunction

   function automatic logic [15:0] pair_value(input logic [1:0] sel);
      if (sel == PAIR_SP) begin
         return sp_m;
      end
      return {regs_m[{sel, 1'b0}], regs_m[{sel, 1'b1}]};
   endfunction

   function automatic void pair_load(input logic [1:0] sel, input logic [15:0] value);
      if (sel == PAIR_SP) begin
         sp_m = value;
      end else begin
         regs_m[{sel, 1'b0}] = value[15:8];
         regs_m[{sel, 1'b1}] = value[7:0];
      end
   endfunction

   function automatic rsp_payload_type execute_instr(input instr_t ins);
      rsp_payload_type r;
      logic [15:0] hl;
      access_type  kind;
      logic [15:0] addr;
      logic [7:0]  data;
      hl   = pair_value(PAIR_HL);
      kind = ACC_NONE;
      addr = '0;
      data = '0;
      case (ins.op)
         OP_LD_R_R: regs_m[ins.tgt] = regs_m[ins.src];
         OP_LD_R_N8: regs_m[ins.tgt] = ins.imm[7:0];
         OP_LD_RR_N16: pair_load(ins.psel, ins.imm);
         OP_ST_HL_R: begin
            kind = ACC_WRITE; addr = hl; data = regs_m[ins.tgt];
         end
         OP_ST_HL_N8: begin
            kind = ACC_WRITE; addr = hl; data = ins.imm[7:0];
         end
         OP_LD_R_HL: begin
            kind = ACC_READ; addr = hl;
         end
         OP_ST_RR_A: begin
            kind = ACC_WRITE; addr = pair_value(ins.psel); data = regs_m[REG_A];
         end
         OP_ST_N16_A: begin
            kind = ACC_WRITE; addr = ins.imm; data = regs_m[REG_A];
         end
         OP_STH_N8_A: begin
            kind = ACC_WRITE; addr = HIGH_PAGE | ins.imm[7:0]; data = regs_m[REG_A];
         end
         OP_STH_C_A: begin
            kind = ACC_WRITE; addr = HIGH_PAGE | regs_m[REG_C]; data = regs_m[REG_A];
         end
         OP_LD_A_RR: begin
            kind = ACC_READ; addr = pair_value(ins.psel);
         end
         OP_LD_A_N16: begin
            kind = ACC_READ; addr = ins.imm;
         end
         OP_LDH_A_N8: begin
            kind = ACC_READ; addr = HIGH_PAGE | ins.imm[7:0];
         end
         OP_LDH_A_C: begin
            kind = ACC_READ; addr = HIGH_PAGE | regs_m[REG_C];
         end
         OP_ST_HLI_A, OP_ST_HLD_A: begin
            kind = ACC_WRITE; addr = hl; data = regs_m[REG_A];
         end
         OP_LD_A_HLD, OP_LD_A_HLI: begin
            kind = ACC_READ; addr = hl;
         end
         default: ;
      endcase
      if (kind == ACC_WRITE) begin
         mem_m[addr] = data;
      end else if (kind == ACC_READ) begin
         data = mem_m[addr];
         if (ins.op == OP_LD_R_HL) begin
            regs_m[ins.tgt] = data;
         end else begin
            regs_m[REG_A] = data;
         end
      end
      if (ins.op == OP_ST_HLI_A || ins.op == OP_LD_A_HLI) begin
         pair_load(PAIR_HL, hl + 16'd1);
      end else if (ins.op == OP_ST_HLD_A || ins.op == OP_LD_A_HLD) begin
         pair_load(PAIR_HL, hl - 16'd1);
      end
      r.access_kind = kind;
      r.access_addr = addr;
      r.access_byte = data;
      r.acc_value   = regs_m[REG_A];
      r.hl_value    = pair_value(PAIR_HL);
      return r;
   endfunction

   function automatic instr_t instr(input logic [4:0] op, input logic [2:0] tgt,
                                    input logic [2:0] src, input logic [1:0] psel,
                                    input logic [15:0] imm);
      instr_t i;
      i.op   = op;
      i.tgt  = tgt;
      i.src  = src;
      i.psel = psel;
      i.imm  = imm;
      return i;
   endfunction

   function automatic logic [15:0] near_addr();
      logic [15:0] bases [4];
      bases[0] = 16'h0000;
      bases[1] = 16'hC000;
      bases[2] = 16'hFF00;
      bases[3] = 16'hFFF8;
      return bases[$urandom_range(3)] + 16'($urandom_range(15));
   endfunction

   function automatic instr_t rand_instr();
      instr_t i;
      if ($urandom_range(99) < 6) begin
         i.op = 5'($urandom_range(OP_UNKNOWN_HI, OP_UNKNOWN_LO));
      end else begin
         i.op = 5'($urandom_range(OP_LD_A_HLI, OP_LD_R_R));
      end
      i.tgt  = 3'($urandom_range(7));
      i.src  = 3'($urandom_range(7));
      i.psel = 2'($urandom_range(3));
      i.imm  = $urandom_range(1) ? near_addr() : 16'($urandom_range(65535));
      return i;
   endfunction

   function automatic void check_field(input string name, input logic [15:0] exp_v,
                                       input logic [15:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
         n_errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) begin
            expected_accesses.push_back(execute_instr(drv_item));
            n_sent++;
         end
         if (pending_instrs.size() != 0 && $urandom_range(99) >= stall_pct()) begin
            drv_item = pending_instrs.pop_front();
            req_chan.valid      <= 1'b1;
            req_chan.op         <= drv_item.op;
            req_chan.target_reg <= drv_item.tgt;
            req_chan.source_reg <= drv_item.src;
            req_chan.pair_sel   <= drv_item.psel;
            req_chan.imm        <= drv_item.imm;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_payload_type exp_r;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_accesses.size() == 0) begin
               $display("%0t: response with no request outstanding: kind %h addr %h",
                        $time, rsp_chan.access_kind, rsp_chan.access_addr);
               n_errors++;
            end else begin
               exp_r = expected_accesses.pop_front();
               check_field("access_kind", exp_r.access_kind, rsp_chan.access_kind);
               check_field("access_addr", exp_r.access_addr, rsp_chan.access_addr);
               check_field("access_byte", exp_r.access_byte, rsp_chan.access_byte);
               check_field("acc_value", exp_r.acc_value, rsp_chan.acc_value);
               check_field("hl_value", exp_r.hl_value, rsp_chan.hl_value);
               n_checked++;
               if (exp_r.access_kind == ACC_READ) n_reads++;
               if (exp_r.access_kind == ACC_WRITE) n_writes++;
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct());
      end
   end

   initial begin
      clock               = 1'b0;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.op         = '0;
      req_chan.target_reg = '0;
      req_chan.source_reg = '0;
      req_chan.pair_sel   = '0;
      req_chan.imm        = '0;
      rsp_chan.ready      = 1'b0;

      pending_instrs.push_back(instr(OP_LD_RR_N16, REG_B, REG_B, PAIR_HL, 16'hFFFF));
      pending_instrs.push_back(instr(OP_LD_R_N8, REG_A, REG_B, PAIR_BC, 16'h12A5));
      pending_instrs.push_back(instr(OP_ST_HLI_A, REG_B, REG_B, PAIR_BC, 16'h0000));
      pending_instrs.push_back(instr(OP_ST_HLD_A, REG_B, REG_B, PAIR_BC, 16'h0000));
      pending_instrs.push_back(instr(OP_LD_R_N8, REG_A, REG_B, PAIR_BC, 16'h0000));
      pending_instrs.push_back(instr(OP_LD_A_HLI, REG_B, REG_B, PAIR_BC, 16'h0000));
      pending_instrs.push_back(instr(OP_LD_A_HLD, REG_B, REG_B, PAIR_BC, 16'h0000));
      pending_instrs.push_back(instr(OP_LD_RR_N16, REG_B, REG_B, PAIR_SP, 16'h8001));
      pending_instrs.push_back(instr(OP_ST_RR_A, REG_B, REG_B, PAIR_SP, 16'h0000));
      pending_instrs.push_back(instr(OP_LD_RR_N16, REG_B, REG_B, PAIR_DE, 16'h8001));
      pending_instrs.push_back(instr(OP_LD_A_RR, REG_B, REG_B, PAIR_DE, 16'h0000));
      pending_instrs.push_back(instr(OP_LD_R_N8, REG_C, REG_B, PAIR_BC, 16'hFFFF));
      pending_instrs.push_back(instr(OP_STH_C_A, REG_B, REG_B, PAIR_BC, 16'h0000));
      pending_instrs.push_back(instr(OP_LDH_A_C, REG_B, REG_B, PAIR_BC, 16'h0000));
      pending_instrs.push_back(instr(OP_STH_N8_A, REG_B, REG_B, PAIR_BC, 16'hAB80));
      pending_instrs.push_back(instr(OP_LDH_A_N8, REG_B, REG_B, PAIR_BC, 16'h0080));
      pending_instrs.push_back(instr(OP_ST_N16_A, REG_B, REG_B, PAIR_BC, 16'hC123));
      pending_instrs.push_back(instr(OP_LD_A_N16, REG_B, REG_B, PAIR_BC, 16'hC123));
      pending_instrs.push_back(instr(OP_LD_R_N8, REG_F, REG_B, PAIR_BC, 16'h00FF));
      pending_instrs.push_back(instr(OP_LD_R_R, REG_B, REG_F, PAIR_BC, 16'h0000));
      pending_instrs.push_back(instr(OP_ST_RR_A, REG_B, REG_B, PAIR_BC, 16'h0000));
      pending_instrs.push_back(instr(OP_LD_RR_N16, REG_B, REG_B, PAIR_HL, 16'h4004));
      pending_instrs.push_back(instr(OP_ST_HL_R, REG_B, REG_B, PAIR_BC, 16'h0000));
      pending_instrs.push_back(instr(OP_ST_HL_N8, REG_B, REG_B, PAIR_BC, 16'hFF5A));
      pending_instrs.push_back(instr(OP_LD_R_HL, REG_H, REG_B, PAIR_BC, 16'h0000));
      pending_instrs.push_back(instr(OP_LD_R_HL, REG_L, REG_B, PAIR_BC, 16'h0000));
      pending_instrs.push_back(instr(OP_UNKNOWN_LO, REG_A, REG_A, PAIR_SP, 16'hFFFF));
      pending_instrs.push_back(instr(OP_UNKNOWN_HI, REG_A, REG_A, PAIR_SP, 16'hFFFF));
      repeat (RANDOM_INSTRS) pending_instrs.push_back(rand_instr());

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_instrs.size() != 0 || req_chan.valid || expected_accesses.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d requests sent, %0d responses checked: %0d reads, %0d writes, %0d no access",
               n_sent, n_checked, n_reads, n_writes, n_checked - n_reads - n_writes);
      if (n_errors == 0 && expected_accesses.size() == 0) begin
         $display("load_store_executor_8bit_cpu_unit verification clean");
      end else begin
         $display("load_store_executor_8bit_cpu_unit verification failed");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("timeout: %0d requests sent, %0d responses checked", n_sent, n_checked);
      $display("load_store_executor_8bit_cpu_unit verification failed");
      $finish;
   end

endmodule
